// ===== rtl/plac_pkg.sv =====
// Shared types, codes and constant tables of the Phong light accumulator.
package plac_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MATERIAL = 3'd7;

	// vector being normalised
	localparam logic [1:0] NSEL_L = 2'd0;
	localparam logic [1:0] NSEL_V = 2'd1;
	localparam logic [1:0] NSEL_R = 2'd2;

	typedef struct packed {
		logic [31:0] hit_x;
		logic [31:0] hit_y;
		logic [31:0] hit_z;
		logic [15:0] normal_x;
		logic [15:0] normal_y;
		logic [15:0] normal_z;
		logic [31:0] light_x;
		logic [31:0] light_y;
		logic [31:0] light_z;
		logic        occluded;
		logic        last_light;
	} in_item_t;

	typedef struct packed {
		logic       load;
		logic       norm_start;
		logic [1:0] norm_sel;
		logic       dot_nl;
		logic       dot_vr;
		logic       rvec;
		logic [1:0] idx;
		logic       pow_start;
		logic       acc;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic norm_done;
		logic pow_done;
		logic shadow;
		logic last;
		logic out_free;
	} sts_t;

	// Q30 roots of one half: entry i is 2^(-1/2^(i+1))
	typedef logic [15:0][30:0] root_tab_t;

	function automatic root_tab_t calc_roots();
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		root_tab_t t;
		c = 64'd1 << 29;
		t = '0;
		for (int i = 0; i < 16; i++) begin
			v = c << 30;
			r = '0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			c = r;
			t[i] = c[30:0];
		end
		return t;
	endfunction

	localparam root_tab_t POW_ROOTS = calc_roots();

endpackage

// ===== rtl/plac_norm.sv =====
// Bit-serial vector normaliser: range shift, sum of squares, root, three divides.
module plac_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] vec [3],
	output logic               done,
	output logic signed [15:0] unit [3]
);

	localparam logic [2:0] N_IDLE = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ = 3'd2;
	localparam logic [2:0] N_ROOT = 3'd3;
	localparam logic [2:0] N_DIV = 3'd4;

	logic [2:0]         state_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [1:0]         idx_q;
	logic [32:0]        mag_q [3];
	logic               neg_q [3];
	logic [32:0]        mx_q;
	logic [49:0]        sum_q;
	logic [50:0]        v_q;
	logic [50:0]        r_q;
	logic [25:0]        rem_q;
	logic [14:0]        quo_q;
	logic signed [15:0] unit_q [3];

	logic [32:0] mag_in [3];
	logic [32:0] mx_in;
	logic [23:0] sq_op;
	logic [47:0] sq;
	logic [49:0] sum_nx;
	logic [50:0] root_b;
	logic [50:0] root_rb;
	logic        root_ge;
	logic [25:0] len;
	logic [25:0] cand;
	logic        div_ge;
	logic [25:0] div_rem;
	logic [14:0] div_quo;
	logic [15:0] quo_ext;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = vec[i][32] ? (33'd0 - vec[i]) : vec[i];
		end
		mx_in = mag_in[0];
		if (mag_in[1] > mx_in) mx_in = mag_in[1];
		if (mag_in[2] > mx_in) mx_in = mag_in[2];
	end

	assign sq_op = mag_q[idx_q][23:0];
	assign sq = sq_op * sq_op;
	assign sum_nx = sum_q + {2'b00, sq};

	assign root_b = 51'd1 << {cnt_q, 1'b0};
	assign root_rb = r_q + root_b;
	assign root_ge = v_q >= root_rb;

	assign len = {1'b0, r_q[24:0]};
	assign cand = (cnt_q == 5'd0) ? {2'b00, mag_q[idx_q][23:0]} : {rem_q[24:0], 1'b0};
	assign div_ge = cand >= len;
	assign div_rem = div_ge ? (cand - len) : cand;
	assign div_quo = {((cnt_q == 5'd0) ? 14'd0 : quo_q[13:0]), div_ge};
	assign quo_ext = {1'b0, div_quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			mx_q <= '0;
			sum_q <= '0;
			v_q <= '0;
			r_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= '0;
				neg_q[i] <= 1'b0;
				unit_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= mag_in[i];
							neg_q[i] <= vec[i][32];
						end
						mx_q <= mx_in;
						if (mx_in == 33'd0) begin
							for (int i = 0; i < 3; i++) unit_q[i] <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					// bring the largest magnitude into [2^23, 2^24)
					if (mx_q[32:24] != 9'd0) begin
						mx_q <= mx_q >> 1;
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (!mx_q[23]) begin
						mx_q <= mx_q << 1;
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						state_q <= N_SQ;
						idx_q <= '0;
						sum_q <= '0;
					end
				end
				N_SQ: begin
					sum_q <= sum_nx;
					if (idx_q == 2'd2) begin
						v_q <= {1'b0, sum_nx};
						r_q <= '0;
						cnt_q <= 5'd25;
						state_q <= N_ROOT;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				N_ROOT: begin
					if (root_ge) begin
						v_q <= v_q - root_rb;
						r_q <= (r_q >> 1) + root_b;
					end else begin
						r_q <= r_q >> 1;
					end
					if (cnt_q == 5'd0) begin
						state_q <= N_DIV;
						idx_q <= '0;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				N_DIV: begin
					rem_q <= div_rem;
					quo_q <= div_quo;
					if (cnt_q == 5'd14) begin
						unit_q[idx_q] <= neg_q[idx_q] ? $signed(16'd0 - quo_ext) : $signed(quo_ext);
						cnt_q <= '0;
						if (idx_q == 2'd2) begin
							state_q <= N_IDLE;
							done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign unit = unit_q;

endmodule

// ===== rtl/plac_pow.sv =====
// Fractional power unit: log2 by repeated squaring, then 2^-x from a root table.
module plac_pow (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [14:0] base,
	input  logic [15:0] expo,
	output logic        done,
	output logic [14:0] result
);

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_NORM = 3'd1;
	localparam logic [2:0] P_LOG = 3'd2;
	localparam logic [2:0] P_MUL = 3'd3;
	localparam logic [2:0] P_EXP = 3'd4;
	localparam logic [2:0] P_OUT = 3'd5;

	logic [2:0]  state_q;
	logic        done_q;
	logic [14:0] result_q;
	logic [14:0] m_q;
	logic [3:0]  k_q;
	logic [3:0]  cnt_q;
	logic [30:0] z_q;
	logic [15:0] frac_q;
	logic [15:0] expo_q;
	logic [11:0] ip_q;
	logic [15:0] f_q;
	logic [30:0] r_q;

	logic [61:0] z_sq;
	logic [31:0] z_t;
	logic [19:0] nl;
	logic [35:0] x_prod;
	logic [61:0] r_prod;
	logic [30:0] r_sh;
	logic        ip_big;

	assign z_sq = z_q * z_q;
	assign z_t = z_sq[61:30];
	assign nl = {k_q, 16'd0} - {4'd0, frac_q};
	assign x_prod = nl * expo_q;
	assign r_prod = r_q * plac_pkg::POW_ROOTS[cnt_q];
	assign r_sh = r_q >> ip_q[4:0];
	assign ip_big = (ip_q[11:5] != 7'd0) || (ip_q[4:0] == 5'd31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q <= 1'b0;
			result_q <= '0;
			m_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			z_q <= '0;
			frac_q <= '0;
			expo_q <= '0;
			ip_q <= '0;
			f_q <= '0;
			r_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						expo_q <= expo;
						if (base == 15'd0) begin
							result_q <= (expo == 16'd0) ? 15'd16384 : 15'd0;
							done_q <= 1'b1;
						end else if (base[14]) begin
							result_q <= 15'd16384;
							done_q <= 1'b1;
						end else begin
							m_q <= base;
							k_q <= '0;
							state_q <= P_NORM;
						end
					end
				end
				P_NORM: begin
					if (!m_q[14]) begin
						m_q <= m_q << 1;
						k_q <= k_q + 4'd1;
					end else begin
						z_q <= {m_q, 16'd0};
						frac_q <= '0;
						cnt_q <= '0;
						state_q <= P_LOG;
					end
				end
				P_LOG: begin
					if (z_t[31]) begin
						z_q <= z_t[31:1];
						frac_q <= frac_q | (16'h8000 >> cnt_q);
					end else begin
						z_q <= z_t[30:0];
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= P_MUL;
				end
				P_MUL: begin
					ip_q <= x_prod[35:24];
					f_q <= x_prod[23:8];
					r_q <= 31'd1 << 30;
					cnt_q <= '0;
					state_q <= P_EXP;
				end
				P_EXP: begin
					if (f_q[4'd15 - cnt_q]) r_q <= r_prod[60:30];
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= P_OUT;
				end
				P_OUT: begin
					result_q <= ip_big ? 15'd0 : r_sh[30:16];
					done_q <= 1'b1;
					state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

// ===== rtl/plac_dp.sv =====
// Datapath: config registers, vectors, dot products, accumulator and result register.
module plac_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [plac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plac_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  plac_pkg::in_item_t               item,
	input  plac_pkg::cmd_t                   cmd,
	output plac_pkg::sts_t                   sts,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [31:0]                      intensity,
	output logic [7:0]                       out_red,
	output logic [7:0]                       out_green,
	output logic [7:0]                       out_blue,
	output logic [7:0]                       out_alpha,
	output logic                             was_shadowed
);

	logic signed [31:0] cam_q [3];
	logic [15:0]        kd_q;
	logic [15:0]        ks_q;
	logic [15:0]        shin_q;
	logic [15:0]        amb_q;
	logic [31:0]        mat_q;

	logic signed [32:0] lv_q [3];
	logic signed [32:0] vv_q [3];
	logic signed [32:0] rv_q [3];
	logic signed [15:0] nrm_q [3];
	logic signed [15:0] ln_q [3];
	logic signed [15:0] vn_q [3];
	logic signed [15:0] rn_q [3];
	logic signed [32:0] nl_q;
	logic signed [32:0] sv_q;
	logic [14:0]        sp_q;
	logic [31:0]        sum_q;
	logic               shadow_q;
	logic               last_q;

	logic               out_valid_q;
	logic [31:0]        out_inten_q;
	logic [7:0]         out_ch_q [4];
	logic               out_shadow_q;

	logic signed [31:0] hit [3];
	logic signed [31:0] lpos [3];
	logic signed [15:0] nin [3];

	logic signed [32:0] norm_vec [3];
	logic               norm_done;
	logic signed [15:0] norm_unit [3];
	logic               pow_done;
	logic [14:0]        pow_res;
	logic [14:0]        s_clamp;
	logic [14:0]        d_clamp;

	logic signed [15:0] dot_a;
	logic signed [15:0] dot_b;
	logic signed [31:0] dot_p;
	logic signed [32:0] dot_ext;
	logic signed [48:0] rv_prod;
	logic signed [49:0] rv_t;
	logic signed [49:0] rv_adj;
	logic signed [32:0] rv_new;
	logic [30:0]        kd_term;
	logic [30:0]        ks_term;
	logic [31:0]        contrib_full;
	logic [32:0]        sum_add;
	logic [19:0]        amb_sh;
	logic [32:0]        inten_sum;
	logic [31:0]        inten;
	logic [39:0]        ch_prod [4];
	logic [7:0]         ch_sat [4];

	function automatic logic [14:0] clamp_dot(input logic signed [32:0] d);
		logic [14:0] r;
		if (d <= 33'sd0) r = 15'd0;
		else if (d >= 33'sd268435456) r = 15'd16384;
		else r = d[28:14];
		return r;
	endfunction

	assign hit[0] = $signed(item.hit_x);
	assign hit[1] = $signed(item.hit_y);
	assign hit[2] = $signed(item.hit_z);
	assign lpos[0] = $signed(item.light_x);
	assign lpos[1] = $signed(item.light_y);
	assign lpos[2] = $signed(item.light_z);
	assign nin[0] = $signed(item.normal_x);
	assign nin[1] = $signed(item.normal_y);
	assign nin[2] = $signed(item.normal_z);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd.norm_sel)
				plac_pkg::NSEL_L: norm_vec[i] = lv_q[i];
				plac_pkg::NSEL_V: norm_vec[i] = vv_q[i];
				default: norm_vec[i] = rv_q[i];
			endcase
		end
	end

	plac_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.vec    (norm_vec),
		.done   (norm_done),
		.unit   (norm_unit)
	);

	assign s_clamp = clamp_dot(sv_q);
	assign d_clamp = clamp_dot(nl_q);

	plac_pow u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.pow_start),
		.base   (s_clamp),
		.expo   (shin_q),
		.done   (pow_done),
		.result (pow_res)
	);

	// one shared multiplier for both dot products
	assign dot_a = cmd.dot_nl ? nrm_q[cmd.idx] : vn_q[cmd.idx];
	assign dot_b = cmd.dot_nl ? ln_q[cmd.idx] : rn_q[cmd.idx];
	assign dot_p = dot_a * dot_b;
	assign dot_ext = {dot_p[31], dot_p};

	// reflection: 2(N.L)N_i / 2^28, truncated toward zero, minus L_i
	assign rv_prod = nl_q * nrm_q[cmd.idx];
	assign rv_t = {rv_prod, 1'b0};
	assign rv_adj = rv_t + (rv_t[49] ? 50'sd268435455 : 50'sd0);
	assign rv_new = {{11{rv_adj[49]}}, rv_adj[49:28]} - {{17{ln_q[cmd.idx][15]}}, ln_q[cmd.idx]};

	assign kd_term = kd_q * d_clamp;
	assign ks_term = ks_q * sp_q;
	assign contrib_full = {1'b0, kd_term} + {1'b0, ks_term};
	assign sum_add = {1'b0, sum_q} + {11'd0, contrib_full[31:10]};

	assign amb_sh = {amb_q, 4'd0};
	assign inten_sum = {1'b0, sum_q} + {13'd0, amb_sh};
	assign inten = shadow_q ? {12'd0, amb_sh} : (inten_sum[32] ? 32'hFFFF_FFFF : inten_sum[31:0]);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ch_prod[i] = mat_q[8*i +: 8] * inten;
			ch_sat[i] = (ch_prod[i][39:24] != 16'd0) ? 8'hFF : ch_prod[i][23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) cam_q[i] <= '0;
			kd_q <= 16'd4096;
			ks_q <= 16'd12288;
			shin_q <= 16'd512;
			amb_q <= 16'd0;
			mat_q <= 32'hFF00_00FF;
		end else if (cfg_we) begin
			case (cfg_index)
				plac_pkg::CFG_CAMERA_X: cam_q[0] <= $signed(cfg_data);
				plac_pkg::CFG_CAMERA_Y: cam_q[1] <= $signed(cfg_data);
				plac_pkg::CFG_CAMERA_Z: cam_q[2] <= $signed(cfg_data);
				plac_pkg::CFG_DIFFUSE: kd_q <= cfg_data[15:0];
				plac_pkg::CFG_SPECULAR: ks_q <= cfg_data[15:0];
				plac_pkg::CFG_SHININESS: shin_q <= cfg_data[15:0];
				plac_pkg::CFG_AMBIENT: amb_q <= cfg_data[15:0];
				plac_pkg::CFG_MATERIAL: mat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lv_q[i] <= '0;
				vv_q[i] <= '0;
				rv_q[i] <= '0;
				nrm_q[i] <= '0;
				ln_q[i] <= '0;
				vn_q[i] <= '0;
				rn_q[i] <= '0;
			end
			nl_q <= '0;
			sv_q <= '0;
			sp_q <= '0;
			sum_q <= '0;
			shadow_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_inten_q <= '0;
			for (int i = 0; i < 4; i++) out_ch_q[i] <= '0;
			out_shadow_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				for (int i = 0; i < 3; i++) begin
					lv_q[i] <= {lpos[i][31], lpos[i]} - {hit[i][31], hit[i]};
					vv_q[i] <= {cam_q[i][31], cam_q[i]} - {hit[i][31], hit[i]};
					nrm_q[i] <= nin[i];
				end
				// shadow is sticky until the last light of the hit
				shadow_q <= shadow_q | item.occluded;
				last_q <= item.last_light;
			end
			if (norm_done) begin
				for (int i = 0; i < 3; i++) begin
					case (cmd.norm_sel)
						plac_pkg::NSEL_L: ln_q[i] <= norm_unit[i];
						plac_pkg::NSEL_V: vn_q[i] <= norm_unit[i];
						default: rn_q[i] <= norm_unit[i];
					endcase
				end
			end
			if (cmd.dot_nl) nl_q <= (cmd.idx == 2'd0) ? dot_ext : nl_q + dot_ext;
			if (cmd.dot_vr) sv_q <= (cmd.idx == 2'd0) ? dot_ext : sv_q + dot_ext;
			if (cmd.rvec) rv_q[cmd.idx] <= rv_new;
			if (pow_done) sp_q <= pow_res;
			if (cmd.acc) sum_q <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				out_inten_q <= inten;
				for (int i = 0; i < 4; i++) out_ch_q[i] <= ch_sat[i];
				out_shadow_q <= shadow_q;
				sum_q <= '0;
				shadow_q <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.norm_done = norm_done;
	assign sts.pow_done = pow_done;
	assign sts.shadow = shadow_q;
	assign sts.last = last_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign intensity = out_inten_q;
	assign out_red = out_ch_q[0];
	assign out_green = out_ch_q[1];
	assign out_blue = out_ch_q[2];
	assign out_alpha = out_ch_q[3];
	assign was_shadowed = out_shadow_q;

endmodule

// ===== rtl/plac_ctrl.sv =====
// Controller: sequences the per-light steps and the result hand-off.
module plac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output plac_pkg::cmd_t cmd,
	input  plac_pkg::sts_t sts
);

	localparam logic [3:0] C_IDLE = 4'd0;
	localparam logic [3:0] C_CHECK = 4'd1;
	localparam logic [3:0] C_NORM_L = 4'd2;
	localparam logic [3:0] C_WAIT_L = 4'd3;
	localparam logic [3:0] C_NORM_V = 4'd4;
	localparam logic [3:0] C_WAIT_V = 4'd5;
	localparam logic [3:0] C_DOT_NL = 4'd6;
	localparam logic [3:0] C_RVEC = 4'd7;
	localparam logic [3:0] C_NORM_R = 4'd8;
	localparam logic [3:0] C_WAIT_R = 4'd9;
	localparam logic [3:0] C_DOT_VR = 4'd10;
	localparam logic [3:0] C_POW = 4'd11;
	localparam logic [3:0] C_WAIT_P = 4'd12;
	localparam logic [3:0] C_ACC = 4'd13;
	localparam logic [3:0] C_FINISH = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic [1:0] idx_q;
	logic [1:0] idx_nx;

	assign in_ready = (state_q == C_IDLE);

	always_comb begin
		state_nx = state_q;
		idx_nx = idx_q;
		cmd = '0;
		cmd.idx = idx_q;
		case (state_q)
			C_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_nx = C_CHECK;
			end
			C_CHECK: state_nx = sts.shadow ? C_FINISH : C_NORM_L;
			C_NORM_L: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sel = plac_pkg::NSEL_L;
				state_nx = C_WAIT_L;
			end
			C_WAIT_L: begin
				cmd.norm_sel = plac_pkg::NSEL_L;
				if (sts.norm_done) state_nx = C_NORM_V;
			end
			C_NORM_V: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sel = plac_pkg::NSEL_V;
				state_nx = C_WAIT_V;
			end
			C_WAIT_V: begin
				cmd.norm_sel = plac_pkg::NSEL_V;
				if (sts.norm_done) begin
					state_nx = C_DOT_NL;
					idx_nx = '0;
				end
			end
			C_DOT_NL: begin
				cmd.dot_nl = 1'b1;
				idx_nx = idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					state_nx = C_RVEC;
					idx_nx = '0;
				end
			end
			C_RVEC: begin
				cmd.rvec = 1'b1;
				idx_nx = idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					state_nx = C_NORM_R;
					idx_nx = '0;
				end
			end
			C_NORM_R: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sel = plac_pkg::NSEL_R;
				state_nx = C_WAIT_R;
			end
			C_WAIT_R: begin
				cmd.norm_sel = plac_pkg::NSEL_R;
				if (sts.norm_done) begin
					state_nx = C_DOT_VR;
					idx_nx = '0;
				end
			end
			C_DOT_VR: begin
				cmd.dot_vr = 1'b1;
				idx_nx = idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					state_nx = C_POW;
					idx_nx = '0;
				end
			end
			C_POW: begin
				cmd.pow_start = 1'b1;
				state_nx = C_WAIT_P;
			end
			C_WAIT_P: if (sts.pow_done) state_nx = C_ACC;
			C_ACC: begin
				cmd.acc = 1'b1;
				state_nx = C_FINISH;
			end
			C_FINISH: begin
				// a result waits here only while the output register is still full
				if (!sts.last) begin
					state_nx = C_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nx = C_IDLE;
				end
			end
			default: state_nx = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_nx;
			idx_q <= idx_nx;
		end
	end

endmodule

// ===== rtl/phong_light_accumulator.sv =====
// Phong light accumulator top level: stream ports, controller and datapath.
// One light at a time. A shadowed light skips the normaliser and the power unit; the time of a lit light is set
// by three passes through the shared bit-serial normaliser (range shift, 26 root steps, 45 divide steps)
// and by the power unit.
// A result sits in an output register, so the next light is taken while it waits.
// arst_n clears the accumulator, shadow flag and result valid; config returns to defaults.
module phong_light_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, light_x, light_y, light_z
	input  logic [239:0]                    s_axis_tdata,
	// occluded
	input  logic                            s_axis_tuser,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// intensity, out_red, out_green, out_blue, out_alpha
	output logic [63:0]                     m_axis_tdata,
	// was_shadowed
	output logic                            m_axis_tuser,
	input  logic                            cfg_we,
	input  logic [plac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plac_pkg::CFG_DATA_W-1:0] cfg_data
);

	plac_pkg::in_item_t item;
	plac_pkg::cmd_t     cmd;
	plac_pkg::sts_t     sts;
	logic [31:0]        intensity;
	logic [7:0]         out_red;
	logic [7:0]         out_green;
	logic [7:0]         out_blue;
	logic [7:0]         out_alpha;

	assign item.hit_x = s_axis_tdata[31:0];
	assign item.hit_y = s_axis_tdata[63:32];
	assign item.hit_z = s_axis_tdata[95:64];
	assign item.normal_x = s_axis_tdata[111:96];
	assign item.normal_y = s_axis_tdata[127:112];
	assign item.normal_z = s_axis_tdata[143:128];
	assign item.light_x = s_axis_tdata[175:144];
	assign item.light_y = s_axis_tdata[207:176];
	assign item.light_z = s_axis_tdata[239:208];
	assign item.occluded = s_axis_tuser;
	assign item.last_light = s_axis_tlast;

	plac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	plac_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.intensity    (intensity),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_alpha    (out_alpha),
		.was_shadowed (m_axis_tuser)
	);

	assign m_axis_tdata = {out_alpha, out_blue, out_green, out_red, intensity};

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a light is still in work");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result written over a pending transfer");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_axis_tvalid)
		else $error("emitted result not presented");

endmodule

// ===== sim/tb_phong_light_accumulator.sv =====
// Self-checking testbench for the Phong light accumulator: directed table, then random hits.
`timescale 1ns / 100ps

module tb_phong_light_accumulator;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 500;

	typedef longint vec3_t [3];

	typedef struct packed {
		logic [31:0]     inten;
		logic [3:0][7:0] chan;
		logic            shadow;
	} pixel_t;

	typedef struct {
		logic [31:0] hx, hy, hz;
		logic [15:0] nx, ny, nz;
		logic [31:0] lx, ly, lz;
		bit          occ, last, typed;
		logic [31:0] t_inten;
		bit          t_shadow;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [239:0] s_axis_tdata;
	logic s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we;
	logic [plac_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [plac_pkg::CFG_DATA_W-1:0] cfg_data;

	phong_light_accumulator dut (.*);

	// shadow copy of the block's registers and state
	logic signed [31:0] cam_x, cam_y, cam_z;
	logic [63:0] kd, ks, shin, amb_lvl, rgba;
	logic [63:0] light_sum;
	bit shadow_seen;

	pixel_t pixel_q [$];
	int errors;
	int cycles;
	bit idle_on;

	dir_row_t dir_tab [13] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 1},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
		'{0, 0, 0, 0, 0, 16'h4000, 0, 0, 32'h000A0000, 0, 1, 0, 0, 0},
		'{0, 0, 32'hFFFB0000, 0, 0, 16'h4000, 0, 0, 32'h00050000, 0, 1, 0, 0, 0},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0},
		'{32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 0, 0, 0},
		'{0, 0, 32'hFFFB0000, 0, 0, 16'h4000, 32'h00030000, 0, 32'h00050000, 0, 0, 0, 0, 0},
		'{0, 0, 32'hFFFB0000, 0, 0, 16'h4000, 0, 32'h00020000, 32'h00050000, 1, 0, 0, 0, 0},
		'{0, 0, 32'hFFFB0000, 0, 0, 16'h4000, 0, 0, 32'h00050000, 0, 1, 0, 0, 0},
		'{0, 0, 32'h00010000, 0, 0, 16'h4000, 32'h00010000, 0, 32'hFFFF0000, 0, 1, 0, 0, 0},
		'{0, 0, 32'hFFFB0000, 0, 16'h1000, 16'hC000, 32'h00020000, 0, 32'h00050000,
			0, 1, 0, 0, 0},
		'{0, 0, 32'hFFFB0000, 0, 0, 0, 32'h00010000, 0, 0, 0, 1, 0, 0, 0},
		'{32'hA5A5A5A5, 32'h5A5A5A5A, 32'h0F0F0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3,
			32'h12345678, 32'hEDCBA987, 32'h55AA55AA, 0, 1, 0, 0, 0}
	};

	function automatic logic [63:0] sq_root(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// range-shift to [2^23, 2^24), then divide by the integer root, giving s1.14
	function automatic void unit_vec(input vec3_t a, output vec3_t o);
		logic [63:0] mag [3];
		logic [63:0] mx, sum, len, q;
		bit neg [3];
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = a[i] < 0;
			mag[i] = neg[i] ? -a[i] : a[i];
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (mx >= (64'd1 << 24)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		end
		while (mx < (64'd1 << 23)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
		end
		for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
		len = sq_root(sum);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] << 14) / len;
			o[i] = neg[i] ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic longint dot_q28(vec3_t a, vec3_t b);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	function automatic logic [63:0] clamp_q14(longint d);
		if (d <= 0) return 0;
		if (d >= (longint'(1) << 28)) return 16384;
		return d >>> 14;
	endfunction

	// s^e with s u1.14, e u8.8: via -log2 by squaring, then 2^-x from roots of 1/2
	function automatic logic [63:0] pow_q14(logic [63:0] s, logic [63:0] e);
		logic [63:0] m, z, frac, nlog, x, ip, f, r, c;
		int k;
		if (s == 0) return (e == 0) ? 64'd16384 : 64'd0;
		if (s >= 16384) return 16384;
		m = s;
		k = 0;
		frac = 0;
		while (m < 16384) begin
			m = m << 1;
			k++;
		end
		z = m << 16;
		for (int i = 0; i < 16; i++) begin
			z = (z * z) >> 30;
			if (z >= (64'd1 << 31)) begin
				z = z >> 1;
				frac = frac | (64'h8000 >> i);
			end
		end
		nlog = 64'(k) * 65536 - frac;
		x = (nlog * e) >> 8;
		ip = x >> 16;
		f = x & 64'hFFFF;
		r = 64'd1 << 30;
		c = 64'd1 << 29;
		for (int i = 0; i < 16; i++) begin
			c = sq_root(c << 30);
			if ((f & (64'h8000 >> i)) != 0) r = (r * c) >> 30;
		end
		if (ip >= 31) return 0;
		r = r >> ip;
		return r >> 16;
	endfunction

	// advances the shadow state by one light; returns 1 when a pixel comes out
	function automatic bit shade_light(input plac_pkg::in_item_t it, output pixel_t px);
		vec3_t hit, nrm, lv, vv, ln, vn, rv, rn;
		longint nl;
		logic [63:0] d, sp, contrib, inten, amb, ch;
		hit = '{longint'($signed(it.hit_x)), longint'($signed(it.hit_y)),
			longint'($signed(it.hit_z))};
		nrm = '{longint'($signed(it.normal_x)), longint'($signed(it.normal_y)),
			longint'($signed(it.normal_z))};
		lv = '{longint'($signed(it.light_x)) - hit[0], longint'($signed(it.light_y)) - hit[1],
			longint'($signed(it.light_z)) - hit[2]};
		vv = '{longint'(cam_x) - hit[0], longint'(cam_y) - hit[1], longint'(cam_z) - hit[2]};
		px = '0;
		if (it.occluded) shadow_seen = 1;
		if (!shadow_seen) begin
			unit_vec(lv, ln);
			unit_vec(vv, vn);
			nl = dot_q28(nrm, ln);
			for (int i = 0; i < 3; i++)
				rv[i] = (2 * nl * nrm[i]) / (longint'(1) << 28) - ln[i];
			unit_vec(rv, rn);
			d = clamp_q14(nl);
			sp = pow_q14(clamp_q14(dot_q28(vn, rn)), shin);
			contrib = (kd * d + ks * sp) >> 10;
			light_sum = light_sum + contrib;
			if (light_sum > 64'hFFFFFFFF) light_sum = 64'hFFFFFFFF;
		end
		if (!it.last_light) return 0;
		amb = amb_lvl << 4;
		inten = shadow_seen ? amb : light_sum + amb;
		if (inten > 64'hFFFFFFFF) inten = 64'hFFFFFFFF;
		px.inten = inten[31:0];
		for (int i = 0; i < 4; i++) begin
			ch = (((rgba >> (8 * i)) & 64'hFF) * inten) >> 16;
			px.chan[i] = (ch > 255) ? 8'd255 : ch[7:0];
		end
		px.shadow = shadow_seen;
		light_sum = 0;
		shadow_seen = 0;
		return 1;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stall bursts
	initial begin : rx_stall
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall == 0 && idle_on && $urandom_range(0, 4) == 0)
				stall = $urandom_range(1, 16);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pixel_q.size() == 0) begin
				report("unexpected transfer", m_axis_tdata[31:0], 0);
			end else begin
				want = pixel_q.pop_front();
				if (m_axis_tdata[31:0] !== want.inten)
					report("intensity", m_axis_tdata[31:0], want.inten);
				if (m_axis_tdata[39:32] !== want.chan[0])
					report("red", m_axis_tdata[39:32], want.chan[0]);
				if (m_axis_tdata[47:40] !== want.chan[1])
					report("green", m_axis_tdata[47:40], want.chan[1]);
				if (m_axis_tdata[55:48] !== want.chan[2])
					report("blue", m_axis_tdata[55:48], want.chan[2]);
				if (m_axis_tdata[63:56] !== want.chan[3])
					report("alpha", m_axis_tdata[63:56], want.chan[3]);
				if (m_axis_tuser !== want.shadow)
					report("was_shadowed", m_axis_tuser, want.shadow);
			end
		end
	end

	task automatic cfg_write(logic [plac_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			plac_pkg::CFG_CAMERA_X: cam_x = val;
			plac_pkg::CFG_CAMERA_Y: cam_y = val;
			plac_pkg::CFG_CAMERA_Z: cam_z = val;
			plac_pkg::CFG_DIFFUSE: kd = val[15:0];
			plac_pkg::CFG_SPECULAR: ks = val[15:0];
			plac_pkg::CFG_SHININESS: shin = val[15:0];
			plac_pkg::CFG_AMBIENT: amb_lvl = val[15:0];
			plac_pkg::CFG_MATERIAL: rgba = val;
			default: ;
		endcase
	endtask

	task automatic apply_cfg(logic [31:0] v [8]);
		cfg_write(plac_pkg::CFG_CAMERA_X, v[0]);
		cfg_write(plac_pkg::CFG_CAMERA_Y, v[1]);
		cfg_write(plac_pkg::CFG_CAMERA_Z, v[2]);
		cfg_write(plac_pkg::CFG_DIFFUSE, v[3]);
		cfg_write(plac_pkg::CFG_SPECULAR, v[4]);
		cfg_write(plac_pkg::CFG_SHININESS, v[5]);
		cfg_write(plac_pkg::CFG_AMBIENT, v[6]);
		cfg_write(plac_pkg::CFG_MATERIAL, v[7]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender holds off until all pixels are back and the last light has cleared the pipe
	task automatic drain();
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_light(plac_pkg::in_item_t it, bit typed, pixel_t typed_px);
		pixel_t px;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.light_z, it.light_y, it.light_x, it.normal_z, it.normal_y,
			it.normal_x, it.hit_z, it.hit_y, it.hit_x};
		s_axis_tuser <= it.occluded;
		s_axis_tlast <= it.last_light;
		do @(posedge clk); while (!s_axis_tready);
		if (shade_light(it, px)) pixel_q.push_back(typed ? typed_px : px);
		@(negedge clk);
	endtask

	function automatic plac_pkg::in_item_t rand_light(bit noise, bit occ, bit last);
		plac_pkg::in_item_t it;
		if (noise) begin
			it = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
				$urandom, $urandom, $urandom, 1'($urandom), 1'($urandom)};
			return it;
		end
		it.hit_x = $urandom_range(0, 2 ** 21) - 2 ** 20;
		it.hit_y = $urandom_range(0, 2 ** 21) - 2 ** 20;
		it.hit_z = $urandom_range(0, 2 ** 21) - 2 ** 20;
		it.normal_x = 16'($urandom_range(0, 8000) - 4000);
		it.normal_y = 16'($urandom_range(0, 8000) - 4000);
		it.normal_z = 16'(16384 - $urandom_range(0, 3000));
		it.light_x = it.hit_x + $urandom_range(0, 2 ** 23) - 2 ** 22;
		it.light_y = it.hit_y + $urandom_range(0, 2 ** 23) - 2 ** 22;
		it.light_z = it.hit_z + $urandom_range(2 ** 16, 2 ** 23);
		it.occluded = occ;
		it.last_light = last;
		return it;
	endfunction

	// one hit of 1 to 4 lights, or the odd stray item
	task automatic rand_hit(output int n);
		int lights;
		if ($urandom_range(0, 9) == 0) begin
			send_light(rand_light(1, 0, 0), 0, '0);
			n = 1;
			return;
		end
		lights = $urandom_range(1, 4);
		for (int i = 0; i < lights; i++)
			send_light(rand_light(0, $urandom_range(0, 7) == 0, i == lights - 1), 0, '0);
		n = lights;
	endtask

	task automatic rand_phase(int items);
		int sent, n;
		sent = 0;
		while (sent < items) begin
			rand_hit(n);
			sent += n;
		end
		// close any hit left open by a stray item
		send_light(rand_light(0, 0, 1), 0, '0);
	endtask

	initial begin
		logic [31:0] cv [8];
		plac_pkg::in_item_t it;
		pixel_t tp;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		idle_on = 1;
		cam_x = 0;
		cam_y = 0;
		cam_z = 0;
		kd = 4096;
		ks = 12288;
		shin = 512;
		amb_lvl = 0;
		rgba = 64'hFF0000FF;
		light_sum = 0;
		shadow_seen = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			it = {dir_tab[i].hx, dir_tab[i].hy, dir_tab[i].hz, dir_tab[i].nx, dir_tab[i].ny,
				dir_tab[i].nz, dir_tab[i].lx, dir_tab[i].ly, dir_tab[i].lz,
				dir_tab[i].occ, dir_tab[i].last};
			tp = '0;
			tp.inten = dir_tab[i].t_inten;
			tp.shadow = dir_tab[i].t_shadow;
			send_light(it, dir_tab[i].typed, tp);
		end
		s_axis_tvalid <= 1'b0;
		drain();

		cv = '{0, 0, 32'h00140000, 32'h0C00, 32'h1000, 32'h0A00, 32'h0100, $urandom};
		apply_cfg(cv);
		rand_phase(100);
		s_axis_tvalid <= 1'b0;
		drain();

		cv = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
			32'hFFFF, 32'hFFFFFFFF};
		apply_cfg(cv);
		rand_phase(80);
		s_axis_tvalid <= 1'b0;
		drain();

		cv = '{32'h80000000, 32'h80000000, 32'h80000000, 0, 32'hFFFF, 0, 0, 32'h00FF00FF};
		apply_cfg(cv);
		rand_phase(80);
		s_axis_tvalid <= 1'b0;
		drain();

		cv = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		apply_cfg(cv);
		rand_phase(80);
		s_axis_tvalid <= 1'b0;
		drain();

		// closing stretch runs flat out on both sides
		idle_on = 0;
		cv = '{32'h00030000, 32'hFFFE0000, 32'h00200000, 32'h0800, 32'h2000,
			$urandom_range(0, 16'h2000), 32'h0200, $urandom};
		apply_cfg(cv);
		rand_phase(150);
		s_axis_tvalid <= 1'b0;
		drain();

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
